// ----- src/cle_pkg.sv -----
// Shared types and codes for the command line editor.
`default_nettype none

package cle_pkg;

    // Field widths fixed by the interface
    localparam int POS_W   = 6;
    localparam int CHAR_W  = 8;
    localparam int OP_W    = 4;
    localparam int KIND_W  = 2;
    localparam int BASE_W  = 12;
    localparam int CELL_W  = 13;

    // Key event codes
    localparam logic [OP_W-1:0] OP_CHAR  = 4'd0;
    localparam logic [OP_W-1:0] OP_ENTER = 4'd1;
    localparam logic [OP_W-1:0] OP_BKSP  = 4'd2;
    localparam logic [OP_W-1:0] OP_DEL   = 4'd3;
    localparam logic [OP_W-1:0] OP_LEFT  = 4'd4;
    localparam logic [OP_W-1:0] OP_RIGHT = 4'd5;
    localparam logic [OP_W-1:0] OP_HOME  = 4'd6;
    localparam logic [OP_W-1:0] OP_END   = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR = 4'd8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TERM   = 2'd2;

    // Printable key range, low inclusive, high exclusive
    localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7F;
    localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;

    // Cell row commands
    localparam logic [1:0] MODE_HOLD = 2'd0;
    localparam logic [1:0] MODE_INS  = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;
    localparam logic [1:0] MODE_ROT  = 2'd3;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic [1:0]        mode;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] key;
    } ctl_t;

endpackage

`default_nettype wire

// ----- src/cle_cell.sv -----
// One character cell of the line buffer row.
`default_nettype none

module cle_cell #(
    parameter int IDX = 0
) (
    input  wire logic                       clk,
    input  wire cle_pkg::ctl_t              ctl,
    input  wire logic [cle_pkg::CHAR_W-1:0] left_data,
    input  wire logic [cle_pkg::CHAR_W-1:0] right_data,
    output logic      [cle_pkg::CHAR_W-1:0] data
);

    localparam logic [cle_pkg::POS_W-1:0] MY_POS = cle_pkg::POS_W'(IDX);

    logic [cle_pkg::CHAR_W-1:0] data_reg;
    logic [cle_pkg::CHAR_W-1:0] data_next;

    // Pick the new character from a neighbor, the key, or hold
    always_comb
    begin
        data_next = data_reg;
        case (ctl.mode)
            cle_pkg::MODE_INS:
            begin
                if (MY_POS > ctl.pos)
                begin
                    data_next = left_data;
                end
                else if (MY_POS == ctl.pos)
                begin
                    data_next = ctl.key;
                end
            end
            cle_pkg::MODE_DEL:
            begin
                if (MY_POS >= ctl.pos)
                begin
                    data_next = right_data;
                end
            end
            cle_pkg::MODE_ROT:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- src/cle_chain.sv -----
// Row of character cells linked as a ring; cell 0 is the read tap.
`default_nettype none

module cle_chain #(
    parameter int N_CELLS = 64
) (
    input  wire logic                       clk,
    input  wire cle_pkg::ctl_t              ctl,
    output logic      [cle_pkg::CHAR_W-1:0] head_char
);

    logic [cle_pkg::CHAR_W-1:0] cell_data [N_CELLS];

    // Link each cell to its neighbors; the ends wrap for rotation
    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        cle_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .left_data  (cell_data[(i + N_CELLS - 1) % N_CELLS]),
            .right_data (cell_data[(i + 1) % N_CELLS]),
            .data       (cell_data[i])
        );
    end

    assign head_char = cell_data[0];

endmodule

`default_nettype wire

// ----- src/command_line_editor_top.sv -----
// Top level of the command line editor: control, cursor state and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | op, key_char
//  out     | output    | out_valid / out_stall| kind, out_char, cursor_pos, line_length,
//          |           |                      | screen_cell, last
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (base position)
//
// An edit shifts the cells from its position onward by one place, all at once.
// On Enter the ring of MAX_LINE cells turns once fully past cell 0, one place per cycle
// unless a line character waits on a stalled output; then the terminator follows.
// Reset clears cursor, length, base position and the result valid flag; the buffer
// contents are undefined until written. A stall holds the result and unsent characters.
`default_nettype none

module command_line_editor_top #(
    parameter int MAX_LINE = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cle_pkg::BASE_W-1:0]  cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [cle_pkg::OP_W-1:0]    op,
    input  wire logic [cle_pkg::CHAR_W-1:0]  key_char,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [cle_pkg::KIND_W-1:0]  kind,
    output logic      [cle_pkg::CHAR_W-1:0]  out_char,
    output logic      [cle_pkg::POS_W-1:0]   cursor_pos,
    output logic      [cle_pkg::POS_W-1:0]   line_length,
    output logic      [cle_pkg::CELL_W-1:0]  screen_cell,
    output logic                             last
);

    localparam int CNT_W = $clog2(MAX_LINE + 1);
    localparam logic [cle_pkg::POS_W-1:0] CAP = cle_pkg::POS_W'(MAX_LINE - 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_LINE);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                          state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [cle_pkg::POS_W-1:0]     cur_reg, cur_next;
    logic [cle_pkg::POS_W-1:0]     len_reg, len_next;
    logic [cle_pkg::BASE_W-1:0]    base_reg;

    logic                          ov_reg, ov_next;
    logic [cle_pkg::KIND_W-1:0]    kind_reg, kind_next;
    logic [cle_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic [cle_pkg::POS_W-1:0]     ocur_reg, ocur_next;
    logic [cle_pkg::POS_W-1:0]     olen_reg, olen_next;
    logic [cle_pkg::CELL_W-1:0]    ocell_reg, ocell_next;
    logic                          last_reg, last_next;

    cle_pkg::ctl_t                 ctl;
    logic [cle_pkg::CHAR_W-1:0]    head_char;
    logic                          accept;
    logic                          slot_free;
    logic                          load;
    logic                          printable;

    // Buffer cells
    cle_chain #(
        .N_CELLS (MAX_LINE)
    ) u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .head_char (head_char)
    );

    assign slot_free = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign printable = (key_char >= cle_pkg::PRINT_LO) && (key_char < cle_pkg::PRINT_HI);

    // Decode the item, drive the cell row and build the next result
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        len_next   = len_reg;
        ctl.mode   = cle_pkg::MODE_HOLD;
        ctl.pos    = cur_reg;
        ctl.key    = key_char;
        load       = 1'b0;
        kind_next  = cle_pkg::KIND_STATUS;
        char_next  = cle_pkg::NUL_CHAR;
        last_next  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == cle_pkg::OP_ENTER)
                    begin
                        state_next = ST_EMIT;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        load = 1'b1;
                        case (op)
                            cle_pkg::OP_CHAR:
                            begin
                                if (printable && (len_reg < CAP))
                                begin
                                    ctl.mode = cle_pkg::MODE_INS;
                                    cur_next = cur_reg + 1'b1;
                                    len_next = len_reg + 1'b1;
                                end
                            end
                            cle_pkg::OP_BKSP:
                            begin
                                if (cur_reg != '0)
                                begin
                                    ctl.mode = cle_pkg::MODE_DEL;
                                    ctl.pos  = cur_reg - 1'b1;
                                    cur_next = cur_reg - 1'b1;
                                    len_next = len_reg - 1'b1;
                                end
                            end
                            cle_pkg::OP_DEL:
                            begin
                                if (cur_reg < len_reg)
                                begin
                                    ctl.mode = cle_pkg::MODE_DEL;
                                    len_next = len_reg - 1'b1;
                                end
                            end
                            cle_pkg::OP_LEFT:
                            begin
                                if (cur_reg != '0)
                                begin
                                    cur_next = cur_reg - 1'b1;
                                end
                            end
                            cle_pkg::OP_RIGHT:
                            begin
                                if (cur_reg < len_reg)
                                begin
                                    cur_next = cur_reg + 1'b1;
                                end
                            end
                            cle_pkg::OP_HOME:
                            begin
                                cur_next = '0;
                            end
                            cle_pkg::OP_END:
                            begin
                                cur_next = len_reg;
                            end
                            cle_pkg::OP_CLEAR:
                            begin
                                cur_next = '0;
                                len_next = '0;
                            end
                            default:
                            begin
                                cur_next = cur_reg;
                            end
                        endcase
                    end
                end
            end
            ST_EMIT:
            begin
                if (cnt_reg != CNT_END)
                begin
                    // Rotate the ring; emit cell 0 while inside the line
                    if (cnt_reg < CNT_W'(len_reg))
                    begin
                        if (slot_free)
                        begin
                            load      = 1'b1;
                            kind_next = cle_pkg::KIND_CHAR;
                            char_next = head_char;
                            last_next = 1'b0;
                            ctl.mode  = cle_pkg::MODE_ROT;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ctl.mode = cle_pkg::MODE_ROT;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (slot_free)
                begin
                    load       = 1'b1;
                    kind_next  = cle_pkg::KIND_TERM;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register fields follow the post-step cursor and length
    assign ocur_next  = cur_next;
    assign olen_next  = len_next;
    assign ocell_next = cle_pkg::CELL_W'(base_reg) + cle_pkg::CELL_W'(cur_next);

    always_comb
    begin
        ov_next = ov_reg;
        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            cur_reg   <= '0;
            len_reg   <= '0;
            base_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            len_reg   <= len_next;
            ov_reg    <= ov_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            char_reg  <= char_next;
            ocur_reg  <= ocur_next;
            olen_reg  <= olen_next;
            ocell_reg <= ocell_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign out_char    = char_reg;
    assign cursor_pos  = ocur_reg;
    assign line_length = olen_reg;
    assign screen_cell = ocell_reg;
    assign last        = last_reg;

    // Cursor never passes the end of the line
    a_cur_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= len_reg)
        else $error("cursor beyond line length");

    // Line never exceeds its capacity
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CAP)
        else $error("line length beyond capacity");

    // Rotation count never passes one full turn of the ring
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> cnt_reg <= CNT_END)
        else $error("rotation count out of range");

    // Line characters are never marked last, everything else is
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (last_reg == (kind_reg != cle_pkg::KIND_CHAR)))
        else $error("last flag does not match result kind");

    // A finished line read leaves the ring in its original order
    a_turn_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |-> cnt_reg == CNT_END)
        else $error("line read ended before a full turn");

endmodule

`default_nettype wire
